### design/ftatc_pkg.sv
// ----------------------------------------------------------------------------
// ftatc_pkg
// Shared types, widths and helpers for the frame count to ATC timecode block.
// ----------------------------------------------------------------------------
package ftatc_pkg;

    localparam int DIV_W  = 32;
    localparam int DEN_W  = 17;
    localparam int TAG_W  = 64;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 8;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_RATE    = 8'd0,
        REG_DROPS_PER_MIN = 8'd1,
        REG_DROP_MODE     = 8'd2,
        REG_ATC_SOURCE    = 8'd3
    } reg_idx_t;

    localparam logic [6:0]  RATE_RESET = 7'd60;
    localparam logic [3:0]  DPM_RESET  = 4'd4;
    localparam logic [1:0]  SRC_VITC1  = 2'd1;
    localparam logic [1:0]  SRC_VITC2  = 2'd2;

    // ceil(2^34 / 15) and ceil(2^20 / 3)
    localparam logic [30:0] RECIP_15   = 31'd1145324613;
    localparam logic [18:0] RECIP_3    = 19'd349526;

    typedef struct packed {
        logic [6:0]  rate;
        logic [3:0]  dpm;
        logic        drop;
        logic [1:0]  source;
        logic [12:0] per_min;
        logic [16:0] per_10min;
        logic [7:0]  dpm9;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] dividend;
        logic [TAG_W-1:0] tag;
    } div_req_t;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
        logic [TAG_W-1:0] tag;
    } div_rsp_t;

    // x / 10 for x below 128
    function automatic logic [3:0] div10(input logic [6:0] x);
        logic [14:0] p;
        p = {8'd0, x} * 15'd205;
        return p[14:11];
    endfunction

endpackage

### design/ftatc_ifs.sv
// ----------------------------------------------------------------------------
// ftatc channel interfaces
// Input item, result item and register write channels.
// ----------------------------------------------------------------------------
interface ftatc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_index;
    modport source (output valid, output frame_index, input ready);
    modport sink   (input valid, input frame_index, output ready);
endinterface

interface ftatc_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [6:0]  frames;
    logic        drop_flag;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
    modport source (output valid, output hours, output minutes, output seconds,
                    output frames, output drop_flag, output payload_low,
                    output payload_high, input ready);
    modport sink   (input valid, input hours, input minutes, input seconds,
                    input frames, input drop_flag, input payload_low,
                    input payload_high, output ready);
endinterface

interface ftatc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ftatc_pkg::IDX_W-1:0]  index;
    logic [ftatc_pkg::DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/frame_count_to_atc_timecode_top.sv
// ----------------------------------------------------------------------------
// frame_count_to_atc_timecode_top
// Frame index to SMPTE timecode and ST 12-2 ATC payload.
// ----------------------------------------------------------------------------
// Stages: three 32-stage dividers, two projection stages, five time split
//   stages and one output register between accepted item and result.
// Throughput: one item per cycle; the whole pipeline holds while the output
//   register is full and not taken.
// Reset: asynchronous, clears all valid bits and loads register defaults.
module frame_count_to_atc_timecode_top (
    input  logic         clk,
    input  logic         rst_n,
    ftatc_in_if.sink     frame,
    ftatc_out_if.source  timecode,
    ftatc_cfg_if.sink    cfg
);

    ftatc_pkg::cfg_t     regs;
    ftatc_pkg::div_req_t req1, req2, req3;
    ftatc_pkg::div_rsp_t rsp1, rsp2, rsp3;
    logic                en;

    logic        va_reg;
    logic [31:0] rema_reg;
    logic [31:0] adda_reg;
    logic [31:0] na_reg;
    logic        vb_reg;
    logic [31:0] projb_reg;
    logic [31:0] rema_next;
    logic [31:0] adda_next;
    logic [31:0] projb_next;

    logic        vs1_reg;
    logic [60:0] prods1_reg;
    logic [5:0]  tsecl1_reg;
    logic [6:0]  frm1_reg;
    logic        vs2_reg;
    logic [26:0] tmin2_reg;
    logic [5:0]  sec2_reg;
    logic [6:0]  frm2_reg;
    logic        vs3_reg;
    logic [55:0] prodm3_reg;
    logic [5:0]  tminl3_reg;
    logic [5:0]  sec3_reg;
    logic [6:0]  frm3_reg;
    logic        vs4_reg;
    logic [20:0] thr4_reg;
    logic [5:0]  min4_reg;
    logic [5:0]  sec4_reg;
    logic [6:0]  frm4_reg;
    logic        vs5_reg;
    logic [4:0]  hr5_reg;
    logic [5:0]  min5_reg;
    logic [5:0]  sec5_reg;
    logic [6:0]  frm5_reg;
    logic [60:0] prods1_next;
    logic [26:0] tmin2_next;
    logic [5:0]  sec2_next;
    logic [55:0] prodm3_next;
    logic [20:0] thr4_next;
    logic [5:0]  min4_next;
    logic [36:0] prodh5;
    logic [4:0]  hr5_next;

    assign en          = !timecode.valid || timecode.ready;
    assign frame.ready = en;

    ftatc_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg), .regs(regs));

    assign req1.valid    = frame.valid;
    assign req1.dividend = frame.frame_index;
    assign req1.tag      = {32'd0, frame.frame_index};

    ftatc_div u_div_blk (.clk(clk), .rst_n(rst_n), .en(en),
                         .divisor(regs.per_10min), .req(req1), .rsp(rsp1));

    always_comb
    begin
        rema_next = (rsp1.remainder > {13'd0, regs.dpm})
                    ? {15'd0, rsp1.remainder - {13'd0, regs.dpm}} : 32'd0;
        adda_next = 32'({24'd0, regs.dpm9} * rsp1.quotient);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= rsp1.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rema_reg <= rema_next;
            adda_reg <= adda_next;
            na_reg   <= rsp1.tag[31:0];
        end
    end

    assign req2.valid    = va_reg;
    assign req2.dividend = rema_reg;
    assign req2.tag      = {adda_reg, na_reg};

    ftatc_div u_div_min (.clk(clk), .rst_n(rst_n), .en(en),
                         .divisor({4'd0, regs.per_min}), .req(req2), .rsp(rsp2));

    always_comb
    begin
        if (regs.drop)
            projb_next = rsp2.tag[31:0] + rsp2.tag[63:32]
                       + 32'({28'd0, regs.dpm} * rsp2.quotient);
        else
            projb_next = rsp2.tag[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= rsp2.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            projb_reg <= projb_next;
    end

    assign req3.valid    = vb_reg;
    assign req3.dividend = projb_reg;
    assign req3.tag      = '0;

    ftatc_div u_div_fps (.clk(clk), .rst_n(rst_n), .en(en),
                         .divisor({10'd0, regs.rate}), .req(req3), .rsp(rsp3));

    // split seconds, minutes and hours: divide by 4 or 8 with a shift, by 15 and 3 with reciprocals
    always_comb
    begin
        prods1_next = 61'(rsp3.quotient[31:2]) * 61'(ftatc_pkg::RECIP_15);
        tmin2_next  = prods1_reg[60:34];
        sec2_next   = {4'(tsecl1_reg[5:2] + prods1_reg[37:34]), tsecl1_reg[1:0]};
        prodm3_next = 56'(tmin2_reg[26:2]) * 56'(ftatc_pkg::RECIP_15);
        thr4_next   = prodm3_reg[54:34];
        min4_next   = {4'(tminl3_reg[5:2] + prodm3_reg[37:34]), tminl3_reg[1:0]};
        prodh5      = 37'(thr4_reg[20:3]) * 37'(ftatc_pkg::RECIP_3);
        hr5_next    = {2'(thr4_reg[4:3] + prodh5[21:20]), thr4_reg[2:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs1_reg <= 1'b0;
            vs2_reg <= 1'b0;
            vs3_reg <= 1'b0;
            vs4_reg <= 1'b0;
            vs5_reg <= 1'b0;
        end
        else if (en)
        begin
            vs1_reg <= rsp3.valid;
            vs2_reg <= vs1_reg;
            vs3_reg <= vs2_reg;
            vs4_reg <= vs3_reg;
            vs5_reg <= vs4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prods1_reg <= prods1_next;
            tsecl1_reg <= rsp3.quotient[5:0];
            frm1_reg   <= rsp3.remainder[6:0];
            tmin2_reg  <= tmin2_next;
            sec2_reg   <= sec2_next;
            frm2_reg   <= frm1_reg;
            prodm3_reg <= prodm3_next;
            tminl3_reg <= tmin2_reg[5:0];
            sec3_reg   <= sec2_reg;
            frm3_reg   <= frm2_reg;
            thr4_reg   <= thr4_next;
            min4_reg   <= min4_next;
            sec4_reg   <= sec3_reg;
            frm4_reg   <= frm3_reg;
            hr5_reg    <= hr5_next;
            min5_reg   <= min4_reg;
            sec5_reg   <= sec4_reg;
            frm5_reg   <= frm4_reg;
        end
    end

    ftatc_fmt u_fmt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .regs     (regs),
        .valid    (vs5_reg),
        .hours    (hr5_reg),
        .minutes  (min5_reg),
        .seconds  (sec5_reg),
        .frames   (frm5_reg),
        .timecode (timecode)
    );

    a_frames_range: assert property (@(posedge clk) disable iff (!rst_n)
        timecode.valid |-> timecode.frames < regs.rate)
        else $error("frames not below frame rate");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        timecode.valid |-> (timecode.seconds < 6'd60 && timecode.minutes < 6'd60
                            && timecode.hours < 5'd24))
        else $error("time field out of range");

    a_drop_bit: assert property (@(posedge clk) disable iff (!rst_n)
        timecode.valid |-> timecode.payload_low[22] == timecode.drop_flag)
        else $error("drop bit in payload differs from drop flag");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && !en) |=> $stable(projb_reg))
        else $error("projection stage moved during stall");

endmodule

### design/ftatc_cfg.sv
// ----------------------------------------------------------------------------
// ftatc_cfg
// Register file with derived per-minute and ten-minute frame counts.
// ----------------------------------------------------------------------------
module ftatc_cfg (
    input  logic               clk,
    input  logic               rst_n,
    ftatc_cfg_if.sink          cfg,
    output ftatc_pkg::cfg_t    regs
);

    logic [6:0]  rate_reg;
    logic [3:0]  dpm_reg;
    logic        drop_reg;
    logic [1:0]  source_reg;
    logic [6:0]  rate_eff_reg;
    logic [12:0] per_min_reg;
    logic [16:0] per_10min_reg;
    logic [7:0]  dpm9_reg;
    logic [6:0]  rate_eff_next;
    logic [12:0] per_min_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= ftatc_pkg::RATE_RESET;
            dpm_reg    <= ftatc_pkg::DPM_RESET;
            drop_reg   <= 1'b0;
            source_reg <= 2'd0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ftatc_pkg::REG_FRAME_RATE:    rate_reg   <= cfg.data[6:0];
                ftatc_pkg::REG_DROPS_PER_MIN: dpm_reg    <= cfg.data[3:0];
                ftatc_pkg::REG_DROP_MODE:     drop_reg   <= cfg.data[0];
                ftatc_pkg::REG_ATC_SOURCE:    source_reg <= cfg.data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rate_eff_next = (rate_reg == 7'd0) ? 7'd1 : rate_reg;
        per_min_next  = {6'd0, rate_eff_next} * 13'd60 - {9'd0, dpm_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_eff_reg  <= ftatc_pkg::RATE_RESET;
            per_min_reg   <= 13'd3596;
            per_10min_reg <= 17'd35964;
            dpm9_reg      <= 8'd36;
        end
        else
        begin
            rate_eff_reg  <= rate_eff_next;
            per_min_reg   <= per_min_next;
            per_10min_reg <= {4'd0, per_min_next} * 17'd10 + {13'd0, dpm_reg};
            dpm9_reg      <= {4'd0, dpm_reg} * 8'd9;
        end
    end

    always_comb
    begin
        regs.rate      = rate_eff_reg;
        regs.dpm       = dpm_reg;
        regs.drop      = drop_reg;
        regs.source    = source_reg;
        regs.per_min   = per_min_reg;
        regs.per_10min = per_10min_reg;
        regs.dpm9      = dpm9_reg;
    end

endmodule

### design/ftatc_div.sv
// ----------------------------------------------------------------------------
// ftatc_div
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module ftatc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [ftatc_pkg::DEN_W-1:0]       divisor,
    input  ftatc_pkg::div_req_t               req,
    output ftatc_pkg::div_rsp_t               rsp
);

    localparam int N = ftatc_pkg::DIV_W;

    logic                            vld_reg  [0:N-1];
    logic [N-1:0]                    quo_reg  [0:N-1];
    logic [ftatc_pkg::DEN_W-1:0]     rem_reg  [0:N-1];
    logic [ftatc_pkg::TAG_W-1:0]     tag_reg  [0:N-1];
    logic                            vld_next [0:N-1];
    logic [N-1:0]                    quo_next [0:N-1];
    logic [ftatc_pkg::DEN_W-1:0]     rem_next [0:N-1];
    logic [ftatc_pkg::TAG_W-1:0]     tag_next [0:N-1];

    always_comb
    begin
        logic [N-1:0]                d_in;
        logic [ftatc_pkg::DEN_W-1:0] r_in;
        logic [ftatc_pkg::DEN_W:0]   trial;
        logic [ftatc_pkg::DEN_W:0]   diff;
        logic                        ge;
        for (int s = 0; s < N; s++)
        begin
            if (s == 0)
            begin
                vld_next[s] = req.valid;
                d_in        = req.dividend;
                r_in        = '0;
                tag_next[s] = req.tag;
            end
            else
            begin
                vld_next[s] = vld_reg[s-1];
                d_in        = quo_reg[s-1];
                r_in        = rem_reg[s-1];
                tag_next[s] = tag_reg[s-1];
            end
            trial       = {r_in, d_in[N-1]};
            diff        = trial - {1'b0, divisor};
            ge          = (trial >= {1'b0, divisor});
            rem_next[s] = ge ? diff[ftatc_pkg::DEN_W-1:0] : trial[ftatc_pkg::DEN_W-1:0];
            quo_next[s] = {d_in[N-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < N; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            for (int s = 0; s < N; s++)
                vld_reg[s] <= vld_next[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < N; s++)
            begin
                quo_reg[s] <= quo_next[s];
                rem_reg[s] <= rem_next[s];
                tag_reg[s] <= tag_next[s];
            end
        end
    end

    always_comb
    begin
        rsp.valid     = vld_reg[N-1];
        rsp.quotient  = quo_reg[N-1];
        rsp.remainder = rem_reg[N-1];
        rsp.tag       = tag_reg[N-1];
    end

endmodule

### design/ftatc_fmt.sv
// ----------------------------------------------------------------------------
// ftatc_fmt
// BCD split, ATC payload packing and output register.
// ----------------------------------------------------------------------------
module ftatc_fmt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ftatc_pkg::cfg_t      regs,
    input  logic                 valid,
    input  logic [4:0]           hours,
    input  logic [5:0]           minutes,
    input  logic [5:0]           seconds,
    input  logic [6:0]           frames,
    ftatc_out_if.source          timecode
);

    logic        valid_reg;
    logic [4:0]  hours_reg;
    logic [5:0]  minutes_reg;
    logic [5:0]  seconds_reg;
    logic [6:0]  frames_reg;
    logic        drop_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_next;
    logic [63:0] hi_next;

    always_comb
    begin
        logic [3:0] f_t, s_t, m_t, h_t;
        logic [3:0] f_u, s_u, m_u, h_u;
        logic [3:0] ftens;
        logic [2:0] dbb1;
        f_t = ftatc_pkg::div10(frames);
        s_t = ftatc_pkg::div10({1'b0, seconds});
        m_t = ftatc_pkg::div10({1'b0, minutes});
        h_t = ftatc_pkg::div10({2'b0, hours});
        f_u = 4'(frames - 7'(f_t * 4'd10));
        s_u = 4'({1'b0, seconds} - 7'(s_t * 4'd10));
        m_u = 4'({1'b0, minutes} - 7'(m_t * 4'd10));
        h_u = 4'({2'b0, hours} - 7'(h_t * 4'd10));
        ftens = {1'b0, regs.drop, f_t[1:0]};
        case (regs.source)
            ftatc_pkg::SRC_VITC1: dbb1 = 3'd1;
            ftatc_pkg::SRC_VITC2: dbb1 = 3'd2;
            default:              dbb1 = 3'd0;
        endcase
        lo_next = '0;
        lo_next[7:4]   = f_u;
        lo_next[23:20] = ftens;
        lo_next[39:36] = s_u;
        lo_next[55:52] = {1'b0, s_t[2:0]};
        for (int i = 0; i < 3; i++)
            lo_next[8*i+3] = dbb1[i];
        hi_next = '0;
        hi_next[7:4]   = m_u;
        hi_next[23:20] = {1'b0, m_t[2:0]};
        hi_next[39:36] = h_u;
        hi_next[55:52] = {2'b0, h_t[1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hours_reg   <= hours;
            minutes_reg <= minutes;
            seconds_reg <= seconds;
            frames_reg  <= frames;
            drop_reg    <= regs.drop;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
        end
    end

    assign timecode.valid        = valid_reg;
    assign timecode.hours        = hours_reg;
    assign timecode.minutes      = minutes_reg;
    assign timecode.seconds      = seconds_reg;
    assign timecode.frames       = frames_reg;
    assign timecode.drop_flag    = drop_reg;
    assign timecode.payload_low  = lo_reg;
    assign timecode.payload_high = hi_reg;

endmodule

### bench/ftatc_test_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftatc bench channel set
// Bundles the three channel instances used by the bench top module.
// ----------------------------------------------------------------------------
interface ftatc_test_chans;
    ftatc_in_if  frame ();
    ftatc_out_if timecode ();
    ftatc_cfg_if cfg ();
endinterface

### bench/frame_count_to_atc_timecode_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_count_to_atc_timecode_top_test
// Sends frame indexes under several rate, drop-frame and source settings,
// predicts hours, minutes, seconds, frames, drop flag and ATC payload for each
// one, and compares every result in order against the predicted timecode.
// ----------------------------------------------------------------------------
module frame_count_to_atc_timecode_top_test;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [6:0]  frames;
        logic        drop_flag;
        logic [63:0] payload_low;
        logic [63:0] payload_high;
    } timecode_t;

    localparam int LATENCY    = 104;
    localparam int WATCHDOG   = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ftatc_test_chans ch ();

    frame_count_to_atc_timecode_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (ch.frame),
        .timecode (ch.timecode),
        .cfg      (ch.cfg)
    );

    logic [6:0] tc_rate;
    logic [3:0] tc_dpm;
    logic       tc_drop;
    logic [1:0] tc_source;

    timecode_t  expected_codes[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         hold_off = 0;
    bit         sink_busy = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] digit_at(input logic [31:0] digit, input int pos);
        logic [63:0] b;
        b = {60'd0, digit[3:0]} << 4;
        return b << (8 * pos);
    endfunction

    function automatic timecode_t convert_frame(input logic [31:0] n);
        timecode_t   t;
        logic [31:0] rate, proj, dpm, per_min, per_10min, blocks, rem, add;
        logic [31:0] fr, tsec, sec, tmin, mins, hrs, dbb1, ftens;
        rate = (tc_rate == 0) ? 32'd1 : {25'd0, tc_rate};
        proj = n;
        if (tc_drop)
        begin
            dpm = {28'd0, tc_dpm};
            per_min = rate * 60 - dpm;
            per_10min = per_min * 10 + dpm;
            blocks = n / per_10min;
            rem = n % per_10min;
            add = dpm * 9 * blocks;
            if (rem > dpm)
                add = add + dpm * ((rem - dpm) / per_min);
            proj = n + add;
        end
        fr = proj % rate;
        tsec = proj / rate;
        sec = tsec % 60;
        tmin = tsec / 60;
        mins = tmin % 60;
        hrs = (tmin / 60) % 24;
        dbb1 = (tc_source == ftatc_pkg::SRC_VITC1) ? 1
             : (tc_source == ftatc_pkg::SRC_VITC2) ? 2 : 0;
        ftens = ((fr / 10) & 3) | (tc_drop ? 4 : 0);
        t.hours = hrs[4:0];
        t.minutes = mins[5:0];
        t.seconds = sec[5:0];
        t.frames = fr[6:0];
        t.drop_flag = tc_drop;
        t.payload_low = digit_at(fr % 10, 0) | digit_at(ftens, 2)
                      | digit_at(sec % 10, 4) | digit_at((sec / 10) & 7, 6);
        t.payload_high = digit_at(mins % 10, 0) | digit_at((mins / 10) & 7, 2)
                       | digit_at(hrs % 10, 4) | digit_at((hrs / 10) & 3, 6);
        for (int i = 0; i < 8; i++)
            if (dbb1[i])
                t.payload_low = t.payload_low | (64'h08 << (8 * i));
        return t;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_frame(input logic [31:0] n, input bit gaps);
        int g;
        g = gaps ? short_gap() : 0;
        if (g > 0)
        begin
            ch.frame.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        ch.frame.valid <= 1'b1;
        ch.frame.frame_index <= n;
        @(posedge clk);
        while (!ch.frame.ready)
            @(posedge clk);
        expected_codes = {expected_codes, convert_frame(n)};
        @(negedge clk);
    endtask

    task automatic write_reg(input ftatc_pkg::reg_idx_t idx, input logic [7:0] value);
        ch.cfg.valid <= 1'b1;
        ch.cfg.index <= idx;
        ch.cfg.data <= value;
        @(posedge clk);
        while (!ch.cfg.ready)
            @(posedge clk);
        case (idx)
            ftatc_pkg::REG_FRAME_RATE:    tc_rate = value[6:0];
            ftatc_pkg::REG_DROPS_PER_MIN: tc_dpm = value[3:0];
            ftatc_pkg::REG_DROP_MODE:     tc_drop = value[0];
            ftatc_pkg::REG_ATC_SOURCE:    tc_source = value[1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        ch.frame.valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic set_timing(input logic [6:0] rate, input logic [3:0] dpm,
                              input bit drop, input logic [1:0] src);
        drain();
        write_reg(ftatc_pkg::REG_FRAME_RATE, {1'b0, rate});
        write_reg(ftatc_pkg::REG_DROPS_PER_MIN, {4'd0, dpm});
        write_reg(ftatc_pkg::REG_DROP_MODE, {7'd0, drop});
        write_reg(ftatc_pkg::REG_ATC_SOURCE, {6'd0, src});
        ch.cfg.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        tc_rate = ftatc_pkg::RATE_RESET;
        tc_dpm = ftatc_pkg::DPM_RESET;
        tc_drop = 1'b0;
        tc_source = 2'd0;
        send_frame(32'd0, 1'b0);
        send_frame(32'd215999, 1'b0);
        send_frame(32'd5183999, 1'b0);
    endtask

    task automatic test_directed_edges();
        set_timing(7'd30, 4'd2, 1'b1, ftatc_pkg::SRC_VITC1);
        send_frame(32'd0, 1'b0);
        send_frame(32'd1, 1'b0);
        send_frame(32'd2, 1'b0);
        send_frame(32'd1799, 1'b0);
        send_frame(32'd1800, 1'b0);
        send_frame(32'd17981, 1'b0);
        send_frame(32'd17982, 1'b0);
        send_frame(32'hFFFF_FFFF, 1'b0);
        set_timing(7'd0, 4'd15, 1'b1, ftatc_pkg::SRC_VITC2);
        send_frame(32'd59, 1'b0);
        send_frame(32'hFFFF_FFFF, 1'b0);
        set_timing(7'd120, 4'd15, 1'b1, 2'd3);
        send_frame(32'd119, 1'b0);
        send_frame(32'd71985, 1'b0);
        send_frame(32'hFFFF_FFF0, 1'b0);
        set_timing(7'd120, 4'd0, 1'b0, 2'd0);
        send_frame(32'd119, 1'b0);
        send_frame(32'hAAAA_AAAA, 1'b0);
        send_frame(32'h5555_5555, 1'b0);
        set_timing(7'd1, 4'd0, 1'b1, ftatc_pkg::SRC_VITC1);
        send_frame(32'd86399, 1'b0);
        send_frame(32'd86400, 1'b0);
    endtask

    task automatic test_random_settings();
        logic [6:0]  rate;
        logic [31:0] n;
        for (int phase = 0; phase < 10; phase++)
        begin
            rate = (phase == 0) ? 7'd0 : (phase == 1) ? 7'd127
                 : 7'($urandom_range(1, 120));
            set_timing(rate, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)));
            for (int k = 0; k < 100; k++)
            begin
                case ($urandom_range(0, 3))
                    0: n = $urandom;
                    1: n = $urandom_range(0, 10000000);
                    2: n = 32'hFFFF_FFFF - $urandom_range(0, 100000);
                    default: n = $urandom_range(0, 200000);
                endcase
                send_frame(n, 1'b1);
            end
        end
    endtask

    task automatic test_back_pressure();
        set_timing(7'd25, 4'd2, 1'b1, ftatc_pkg::SRC_VITC2);
        hold_off = 600;
        for (int k = 0; k < 130; k++)
            send_frame($urandom, 1'b0);
    endtask

    // result sink: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            ch.timecode.ready <= 1'b0;
        end
        else
            ch.timecode.ready <= sink_busy ? 1'b1 : ($urandom_range(0, 9) < 7);
    end

    always @(posedge clk)
    begin
        if (rst_n) sink_busy <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        timecode_t w;
        if (rst_n && ch.timecode.valid && ch.timecode.ready)
        begin
            if (expected_codes.size() == 0)
                report_mismatch("unexpected result", 64'd0, 64'd0);
            else
            begin
                w = expected_codes.pop_front();
                if (ch.timecode.hours !== w.hours)
                    report_mismatch("hours", 64'(ch.timecode.hours), 64'(w.hours));
                if (ch.timecode.minutes !== w.minutes)
                    report_mismatch("minutes", 64'(ch.timecode.minutes), 64'(w.minutes));
                if (ch.timecode.seconds !== w.seconds)
                    report_mismatch("seconds", 64'(ch.timecode.seconds), 64'(w.seconds));
                if (ch.timecode.frames !== w.frames)
                    report_mismatch("frames", 64'(ch.timecode.frames), 64'(w.frames));
                if (ch.timecode.drop_flag !== w.drop_flag)
                    report_mismatch("drop_flag", 64'(ch.timecode.drop_flag),
                                    64'(w.drop_flag));
                if (ch.timecode.payload_low !== w.payload_low)
                    report_mismatch("payload_low", ch.timecode.payload_low, w.payload_low);
                if (ch.timecode.payload_high !== w.payload_high)
                    report_mismatch("payload_high", ch.timecode.payload_high,
                                    w.payload_high);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((ch.frame.valid && ch.frame.ready) || (ch.timecode.valid && ch.timecode.ready)
            || (ch.cfg.valid && ch.cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        ch.frame.valid = 1'b0;
        ch.frame.frame_index = '0;
        ch.cfg.valid = 1'b0;
        ch.cfg.index = '0;
        ch.cfg.data = '0;
        ch.timecode.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_directed_edges();
        test_random_settings();
        test_back_pressure();
        drain();
        repeat (LATENCY) @(negedge clk);
        if (mismatches == 0 && expected_codes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
